// ===== rtl/stsw_pkg.sv =====
// Shared types, codes and constants of the simulated tempering switch.
package stsw_pkg;

	localparam int TEMPS_DEF = 64;

	localparam logic [31:0] BETA_MIN_RST  = 32'h0100_0000;
	localparam logic [31:0] BETA_STEP_RST = 32'h0000_0000;
	localparam logic [6:0]  NUM_TEMPS_RST = 7'd64;
	localparam logic [15:0] PERIOD_RST    = 16'd1;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [15:0] HALF_DRAW = 16'h8000;
	localparam logic [17:0] SCALE_ONE = 18'h10000;
	localparam logic [17:0] SCALE_MAX = 18'h3FFFF;
	localparam logic [31:0] BETA_SAT  = 32'hFFFF_FFFF;
	localparam logic [42:0] Y_LIMIT   = 43'd786432;

	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_UP   = 2'b01;
	localparam logic [1:0] DIR_DN   = 2'b11;

	localparam logic [4:0] TAYLOR_LAST = 5'd16;
	localparam logic [4:0] SQUARE_LAST = 5'd3;
	localparam logic [4:0] SQRT_LAST   = 5'd31;

	localparam logic [6:0] DIV_BITS_MOD  = 7'd32;
	localparam logic [6:0] DIV_BITS_MEAN = 7'd48;
	localparam logic [6:0] DIV_BITS_TERM = 7'd33;
	localparam logic [6:0] DIV_BITS_SCL  = 7'd64;

	typedef enum logic [1:0] {
		REG_BETA_MIN  = 2'd0,
		REG_BETA_STEP = 2'd1,
		REG_NUM_TEMPS = 2'd2,
		REG_PERIOD    = 2'd3
	} cfg_reg_t;

	typedef enum logic [5:0] {
		OP_IDLE, OP_CLEAR, OP_LOAD, OP_MOD_START, OP_RD_CUR, OP_REC, OP_RD_TGT,
		OP_TGT_CAP, OP_BMUL_CUR, OP_BMUL_TGT, OP_BADD_O, OP_BADD_T, OP_BADD_N,
		OP_MC_START, OP_MC_CAP, OP_MT_START, OP_MT_CAP, OP_PAIR, OP_Y1, OP_Y2,
		OP_YSUM, OP_EXP_INIT, OP_TERM_MUL, OP_TDIV_START, OP_TERM_ACC, OP_CLAMP,
		OP_SQUARE, OP_DECIDE, OP_SDIV_START, OP_SQRT_INIT, OP_SQRT_STEP,
		OP_SCL_SAT, OP_EMIT
	} dp_op_t;

	typedef enum logic [5:0] {
		S_CLEAR, S_IDLE, S_MOD_GO, S_MOD_W, S_RD_CUR, S_REC, S_DIRCHK, S_RD_TGT,
		S_TGT_CAP, S_BM_O, S_BA_O, S_BM_T, S_BA_T, S_MC_GO, S_MC_W, S_MT_GO,
		S_MT_W, S_PAIR, S_Y1, S_Y2, S_YSUM, S_EXPI, S_TMUL, S_TDIV_GO, S_TDIV_W,
		S_CLAMP, S_SQ, S_DECIDE, S_OKCHK, S_SDIV_GO, S_SDIV_W, S_SQRT, S_SSAT,
		S_BM_N, S_BA_N, S_EMIT
	} state_t;

	typedef struct packed {
		logic       div_busy;
		logic       is_switch;
		logic       dir_nz;
		logic       accept_now;
		logic       y_big;
		logic       ok;
		logic       newb_zero;
		logic       clr_last;
		logic       out_free;
		logic [4:0] iter;
	} dp_stat_t;

endpackage

// ===== rtl/stsw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stsw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/stsw_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module stsw_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	input  logic [6:0]  nbits,
	output logic        busy,
	output logic [63:0] quot,
	output logic [31:0] rem
);

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic [63:0] dd_q;
	logic [63:0] quot_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [32:0] trial;
	logic        ge;

	assign trial = {rem_q, dd_q[63]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dd_q   <= dividend << (7'd64 - nbits);
			dsr_q  <= divisor;
			quot_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			dd_q   <= {dd_q[62:0], 1'b0};
			quot_q <= {quot_q[62:0], ge};
			rem_q  <= ge ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/stsw_ctrl.sv =====
// Sequencer that steps the datapath through one temperature move.
module stsw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  stsw_pkg::dp_stat_t st,
	output stsw_pkg::dp_op_t   op
);

	stsw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stsw_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stsw_pkg::S_CLEAR:   if (st.clr_last) state_d = stsw_pkg::S_IDLE;
			stsw_pkg::S_IDLE:    if (in_valid) state_d = stsw_pkg::S_MOD_GO;
			stsw_pkg::S_MOD_GO:  state_d = stsw_pkg::S_MOD_W;
			stsw_pkg::S_MOD_W: begin
				if (!st.div_busy) begin
					state_d = st.is_switch ? stsw_pkg::S_RD_CUR : stsw_pkg::S_BM_N;
				end
			end
			stsw_pkg::S_RD_CUR:  state_d = stsw_pkg::S_REC;
			stsw_pkg::S_REC:     state_d = stsw_pkg::S_DIRCHK;
			stsw_pkg::S_DIRCHK:  state_d = st.dir_nz ? stsw_pkg::S_RD_TGT : stsw_pkg::S_BM_N;
			stsw_pkg::S_RD_TGT:  state_d = stsw_pkg::S_TGT_CAP;
			stsw_pkg::S_TGT_CAP: state_d = stsw_pkg::S_BM_O;
			stsw_pkg::S_BM_O:    state_d = stsw_pkg::S_BA_O;
			stsw_pkg::S_BA_O:    state_d = stsw_pkg::S_BM_T;
			stsw_pkg::S_BM_T:    state_d = stsw_pkg::S_BA_T;
			stsw_pkg::S_BA_T:    state_d = stsw_pkg::S_MC_GO;
			stsw_pkg::S_MC_GO:   state_d = stsw_pkg::S_MC_W;
			stsw_pkg::S_MC_W:    if (!st.div_busy) state_d = stsw_pkg::S_MT_GO;
			stsw_pkg::S_MT_GO:   state_d = stsw_pkg::S_MT_W;
			stsw_pkg::S_MT_W:    if (!st.div_busy) state_d = stsw_pkg::S_PAIR;
			stsw_pkg::S_PAIR:    state_d = stsw_pkg::S_Y1;
			stsw_pkg::S_Y1:      state_d = st.accept_now ? stsw_pkg::S_DECIDE : stsw_pkg::S_Y2;
			stsw_pkg::S_Y2:      state_d = stsw_pkg::S_YSUM;
			stsw_pkg::S_YSUM:    state_d = stsw_pkg::S_EXPI;
			stsw_pkg::S_EXPI:    state_d = st.y_big ? stsw_pkg::S_DECIDE : stsw_pkg::S_TMUL;
			stsw_pkg::S_TMUL:    state_d = stsw_pkg::S_TDIV_GO;
			stsw_pkg::S_TDIV_GO: state_d = stsw_pkg::S_TDIV_W;
			stsw_pkg::S_TDIV_W: begin
				if (!st.div_busy) begin
					state_d = (st.iter == stsw_pkg::TAYLOR_LAST) ?
						stsw_pkg::S_CLAMP : stsw_pkg::S_TMUL;
				end
			end
			stsw_pkg::S_CLAMP:   state_d = stsw_pkg::S_SQ;
			stsw_pkg::S_SQ:      if (st.iter == stsw_pkg::SQUARE_LAST) state_d = stsw_pkg::S_DECIDE;
			stsw_pkg::S_DECIDE:  state_d = stsw_pkg::S_OKCHK;
			stsw_pkg::S_OKCHK: begin
				state_d = (st.ok && !st.newb_zero) ? stsw_pkg::S_SDIV_GO : stsw_pkg::S_BM_N;
			end
			stsw_pkg::S_SDIV_GO: state_d = stsw_pkg::S_SDIV_W;
			stsw_pkg::S_SDIV_W:  if (!st.div_busy) state_d = stsw_pkg::S_SQRT;
			stsw_pkg::S_SQRT:    if (st.iter == stsw_pkg::SQRT_LAST) state_d = stsw_pkg::S_SSAT;
			stsw_pkg::S_SSAT:    state_d = stsw_pkg::S_BM_N;
			stsw_pkg::S_BM_N:    state_d = stsw_pkg::S_BA_N;
			stsw_pkg::S_BA_N:    state_d = stsw_pkg::S_EMIT;
			stsw_pkg::S_EMIT:    if (st.out_free) state_d = stsw_pkg::S_IDLE;
			default:             state_d = stsw_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		op       = stsw_pkg::OP_IDLE;
		in_stall = 1'b1;
		unique case (state_q)
			stsw_pkg::S_CLEAR:   op = stsw_pkg::OP_CLEAR;
			stsw_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) op = stsw_pkg::OP_LOAD;
			end
			stsw_pkg::S_MOD_GO:  op = stsw_pkg::OP_MOD_START;
			stsw_pkg::S_RD_CUR:  op = stsw_pkg::OP_RD_CUR;
			stsw_pkg::S_REC:     op = stsw_pkg::OP_REC;
			stsw_pkg::S_RD_TGT:  op = stsw_pkg::OP_RD_TGT;
			stsw_pkg::S_TGT_CAP: op = stsw_pkg::OP_TGT_CAP;
			stsw_pkg::S_BM_O:    op = stsw_pkg::OP_BMUL_CUR;
			stsw_pkg::S_BA_O:    op = stsw_pkg::OP_BADD_O;
			stsw_pkg::S_BM_T:    op = stsw_pkg::OP_BMUL_TGT;
			stsw_pkg::S_BA_T:    op = stsw_pkg::OP_BADD_T;
			stsw_pkg::S_MC_GO:   op = stsw_pkg::OP_MC_START;
			stsw_pkg::S_MC_W:    if (!st.div_busy) op = stsw_pkg::OP_MC_CAP;
			stsw_pkg::S_MT_GO:   op = stsw_pkg::OP_MT_START;
			stsw_pkg::S_MT_W:    if (!st.div_busy) op = stsw_pkg::OP_MT_CAP;
			stsw_pkg::S_PAIR:    op = stsw_pkg::OP_PAIR;
			stsw_pkg::S_Y1:      op = stsw_pkg::OP_Y1;
			stsw_pkg::S_Y2:      op = stsw_pkg::OP_Y2;
			stsw_pkg::S_YSUM:    op = stsw_pkg::OP_YSUM;
			stsw_pkg::S_EXPI:    op = stsw_pkg::OP_EXP_INIT;
			stsw_pkg::S_TMUL:    op = stsw_pkg::OP_TERM_MUL;
			stsw_pkg::S_TDIV_GO: op = stsw_pkg::OP_TDIV_START;
			stsw_pkg::S_TDIV_W:  if (!st.div_busy) op = stsw_pkg::OP_TERM_ACC;
			stsw_pkg::S_CLAMP:   op = stsw_pkg::OP_CLAMP;
			stsw_pkg::S_SQ:      op = stsw_pkg::OP_SQUARE;
			stsw_pkg::S_DECIDE:  op = stsw_pkg::OP_DECIDE;
			stsw_pkg::S_SDIV_GO: op = stsw_pkg::OP_SDIV_START;
			stsw_pkg::S_SDIV_W:  if (!st.div_busy) op = stsw_pkg::OP_SQRT_INIT;
			stsw_pkg::S_SQRT:    op = stsw_pkg::OP_SQRT_STEP;
			stsw_pkg::S_SSAT:    op = stsw_pkg::OP_SCL_SAT;
			stsw_pkg::S_BM_N:    op = stsw_pkg::OP_BMUL_CUR;
			stsw_pkg::S_BA_N:    op = stsw_pkg::OP_BADD_N;
			stsw_pkg::S_EMIT:    if (st.out_free) op = stsw_pkg::OP_EMIT;
			default:             op = stsw_pkg::OP_IDLE;
		endcase
	end

endmodule

// ===== rtl/stsw_dp.sv =====
// Datapath: configuration, rung statistics, Metropolis test and momentum scale.
module stsw_dp #(
	parameter int TEMPS = stsw_pkg::TEMPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stsw_pkg::dp_op_t   op,
	output stsw_pkg::dp_stat_t st,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [31:0]        step_number,
	input  logic signed [31:0] potential,
	input  logic [15:0]        uniform_draw,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               attempted,
	output logic               accepted,
	output logic signed [1:0]  direction,
	output logic [5:0]         rung_index,
	output logic [31:0]        beta_now,
	output logic [17:0]        momentum_scale
);

	localparam int RW = $clog2(TEMPS);

	function automatic logic [RW-1:0] top_of(input logic [6:0] nt);
		logic [31:0] w;
		w = {25'b0, nt};
		return (w == 32'd0) ? '0 :
			(w >= 32'(TEMPS)) ? RW'(TEMPS - 1) : RW'(w - 32'd1);
	endfunction

	logic [31:0] beta_min_q, beta_step_q;
	logic [6:0]  num_temps_q;
	logic [15:0] period_q;
	logic [RW-1:0] rung_q, tgt_q, clr_addr_q, top, bidx;
	logic [4:0]  iter_q;
	logic        ovalid_q;

	logic [31:0]        step_q;
	logic signed [31:0] v_q;
	logic [15:0]        u_q;
	logic               res_att_q, res_acc_q, ok_q;
	logic [1:0]         res_dir_q, dir_c;
	logic [17:0]        res_scale_q;
	logic signed [47:0] cur_sum_q, tgt_sum_q;
	logic [15:0]        cur_cnt_q, tgt_cnt_q;
	logic [RW+31:0]     bprod_q;
	logic [31:0]        bo_q, bt_q, bn_q;
	logic signed [32:0] mc_q, mt_q;
	logic signed [33:0] d_q;
	logic [31:0]        delta_q;
	logic [41:0]        p1_q;
	logic [31:0]        p2_q;
	logic [42:0]        yq_q;
	logic [31:0]        r_q, ev_q;
	logic [32:0]        term_q;
	logic signed [34:0] tsum_q;
	logic [63:0]        sq_q, sres_q, sbit_q;

	logic        oatt_q, oacc_q;
	logic [1:0]  odir_q;
	logic [5:0]  orung_q;
	logic [31:0] obeta_q;
	logic [17:0] oscale_q;

	logic               ram_we, ram_re;
	logic [RW-1:0]      ram_waddr, ram_raddr;
	logic [63:0]        ram_wdata, ram_rdata;
	logic signed [47:0] rd_sum, nsum;
	logic [15:0]        rd_cnt, ncnt;

	logic        div_start, div_busy;
	logic [63:0] div_dividend, div_quot;
	logic [31:0] div_divisor, div_rem;
	logic [6:0]  div_nbits;

	logic [RW+32:0]     bsum;
	logic [31:0]        bsat;
	logic [47:0]        cur_mag, tgt_mag;
	logic signed [32:0] qmean;
	logic signed [33:0] ms, mhalf, m34;
	logic               up;
	logic [33:0]        a;
	logic [55:0]        p2w;
	logic [64:0]        tp;
	logic [63:0]        sqp, strial;
	logic [15:0]        e16;
	logic               okc;
	logic [RW+5:0]      rung_ext;

	assign top = top_of(num_temps_q);
	assign up  = res_dir_q == stsw_pkg::DIR_UP;

	always_comb begin
		dir_c = stsw_pkg::DIR_NONE;
		if (u_q >= stsw_pkg::HALF_DRAW && rung_q < top) dir_c = stsw_pkg::DIR_UP;
		else if (u_q < stsw_pkg::HALF_DRAW && rung_q != '0) dir_c = stsw_pkg::DIR_DN;
	end

	// Rung statistics: sum in the upper 48 bits, count in the lower 16
	assign rd_sum = $signed(ram_rdata[63:16]);
	assign rd_cnt = ram_rdata[15:0];
	assign nsum   = (rd_cnt < stsw_pkg::COUNT_MAX) ? rd_sum + 48'(v_q) : rd_sum;
	assign ncnt   = (rd_cnt < stsw_pkg::COUNT_MAX) ? rd_cnt + 16'd1 : rd_cnt;

	assign ram_we    = (op == stsw_pkg::OP_CLEAR) || (op == stsw_pkg::OP_REC);
	assign ram_waddr = (op == stsw_pkg::OP_CLEAR) ? clr_addr_q : rung_q;
	assign ram_wdata = (op == stsw_pkg::OP_CLEAR) ? 64'd0 : {nsum, ncnt};
	assign ram_re    = (op == stsw_pkg::OP_RD_CUR) || (op == stsw_pkg::OP_RD_TGT);
	assign ram_raddr = (op == stsw_pkg::OP_RD_TGT) ? tgt_q : rung_q;

	stsw_ram #(.WIDTH(64), .DEPTH(TEMPS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cur_mag = cur_sum_q[47] ? 48'(-cur_sum_q) : 48'(cur_sum_q);
	assign tgt_mag = tgt_sum_q[47] ? 48'(-tgt_sum_q) : 48'(tgt_sum_q);

	always_comb begin
		div_start    = 1'b1;
		div_dividend = {32'b0, step_q};
		div_divisor  = {16'b0, (period_q == 16'd0) ? 16'd1 : period_q};
		div_nbits    = stsw_pkg::DIV_BITS_MOD;
		unique case (op)
			stsw_pkg::OP_MOD_START: ;
			stsw_pkg::OP_MC_START: begin
				div_dividend = {16'b0, cur_mag};
				div_divisor  = {16'b0, cur_cnt_q};
				div_nbits    = stsw_pkg::DIV_BITS_MEAN;
			end
			stsw_pkg::OP_MT_START: begin
				div_dividend = {16'b0, tgt_mag};
				div_divisor  = {16'b0, tgt_cnt_q};
				div_nbits    = stsw_pkg::DIV_BITS_MEAN;
			end
			stsw_pkg::OP_TDIV_START: begin
				div_dividend = {31'b0, term_q};
				div_divisor  = {27'b0, iter_q};
				div_nbits    = stsw_pkg::DIV_BITS_TERM;
			end
			stsw_pkg::OP_SDIV_START: begin
				div_dividend = {bo_q, 32'b0};
				div_divisor  = bt_q;
				div_nbits    = stsw_pkg::DIV_BITS_SCL;
			end
			default: div_start = 1'b0;
		endcase
	end

	stsw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.nbits    (div_nbits),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign bidx   = (op == stsw_pkg::OP_BMUL_TGT) ? tgt_q : rung_q;
	assign bsum   = {(RW + 1)'(0), beta_min_q} + {1'b0, bprod_q};
	assign bsat   = (|bsum[RW+32:32]) ? stsw_pkg::BETA_SAT : bsum[31:0];
	assign qmean  = $signed({1'b0, div_quot[31:0]});
	assign ms     = 34'(mc_q) + 34'(mt_q);
	assign mhalf  = (ms + $signed({33'b0, ms[33]})) >>> 1;
	assign m34    = (up && tgt_cnt_q == 16'd0) ? 34'(mc_q) : mhalf;
	assign a      = 34'(-d_q);
	assign p2w    = {32'b0, a[23:0]} * {24'b0, delta_q};
	assign tp     = {32'b0, term_q} * {33'b0, r_q};
	assign sqp    = {32'b0, ev_q} * {32'b0, ev_q};
	assign strial = sres_q + sbit_q;
	assign e16    = st.y_big ? 16'd0 : ev_q[31:16];
	assign okc    = st.accept_now || (e16 >= u_q);
	assign rung_ext = {6'b0, rung_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_min_q  <= stsw_pkg::BETA_MIN_RST;
			beta_step_q <= stsw_pkg::BETA_STEP_RST;
			num_temps_q <= stsw_pkg::NUM_TEMPS_RST;
			period_q    <= stsw_pkg::PERIOD_RST;
			rung_q      <= top_of(stsw_pkg::NUM_TEMPS_RST);
			clr_addr_q  <= '0;
			iter_q      <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (stsw_pkg::cfg_reg_t'(cfg_index))
					stsw_pkg::REG_BETA_MIN:  beta_min_q <= cfg_data;
					stsw_pkg::REG_BETA_STEP: beta_step_q <= cfg_data;
					stsw_pkg::REG_NUM_TEMPS: begin
						num_temps_q <= cfg_data[6:0];
						rung_q      <= top_of(cfg_data[6:0]);
					end
					stsw_pkg::REG_PERIOD:    period_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (op == stsw_pkg::OP_CLEAR) clr_addr_q <= clr_addr_q + RW'(1);
			if (op == stsw_pkg::OP_DECIDE && okc) rung_q <= tgt_q;
			unique case (op)
				stsw_pkg::OP_EXP_INIT: iter_q <= 5'd1;
				stsw_pkg::OP_CLAMP, stsw_pkg::OP_SQRT_INIT: iter_q <= 5'd0;
				stsw_pkg::OP_TERM_ACC, stsw_pkg::OP_SQUARE, stsw_pkg::OP_SQRT_STEP:
					iter_q <= iter_q + 5'd1;
				default: ;
			endcase
			if (op == stsw_pkg::OP_EMIT) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			stsw_pkg::OP_LOAD: begin
				step_q      <= step_number;
				v_q         <= potential;
				u_q         <= uniform_draw;
				res_att_q   <= 1'b0;
				res_acc_q   <= 1'b0;
				res_dir_q   <= stsw_pkg::DIR_NONE;
				res_scale_q <= stsw_pkg::SCALE_ONE;
			end
			stsw_pkg::OP_REC: begin
				res_att_q <= 1'b1;
				res_dir_q <= dir_c;
				tgt_q     <= (dir_c == stsw_pkg::DIR_UP) ? rung_q + RW'(1) : rung_q - RW'(1);
				cur_sum_q <= nsum;
				cur_cnt_q <= ncnt;
			end
			stsw_pkg::OP_TGT_CAP: begin
				tgt_sum_q <= rd_sum;
				tgt_cnt_q <= rd_cnt;
			end
			stsw_pkg::OP_BMUL_CUR, stsw_pkg::OP_BMUL_TGT:
				bprod_q <= {32'b0, bidx} * {RW'(0), beta_step_q};
			stsw_pkg::OP_BADD_O: bo_q <= bsat;
			stsw_pkg::OP_BADD_T: bt_q <= bsat;
			stsw_pkg::OP_BADD_N: bn_q <= bsat;
			stsw_pkg::OP_MC_CAP:
				mc_q <= (cur_cnt_q == 16'd0) ? 33'sd0 : (cur_sum_q[47] ? -qmean : qmean);
			stsw_pkg::OP_MT_CAP:
				mt_q <= (tgt_cnt_q == 16'd0) ? 33'sd0 : (tgt_sum_q[47] ? -qmean : qmean);
			stsw_pkg::OP_PAIR: begin
				d_q     <= up ? m34 - 34'(v_q) : 34'(v_q) - m34;
				delta_q <= up ? bt_q - bo_q : bo_q - bt_q;
			end
			stsw_pkg::OP_Y1:   p1_q <= {32'b0, a[33:24]} * {10'b0, delta_q};
			stsw_pkg::OP_Y2:   p2_q <= p2w[55:24];
			stsw_pkg::OP_YSUM: yq_q <= {1'b0, p1_q} + {11'b0, p2_q};
			stsw_pkg::OP_EXP_INIT: begin
				r_q    <= {yq_q[19:0], 12'b0};
				term_q <= 33'h1_0000_0000;
				tsum_q <= 35'sh1_0000_0000;
			end
			stsw_pkg::OP_TERM_MUL: term_q <= tp[64:32];
			stsw_pkg::OP_TERM_ACC: begin
				term_q <= div_quot[32:0];
				if (iter_q[0]) tsum_q <= tsum_q - $signed({2'b0, div_quot[32:0]});
				else tsum_q <= tsum_q + $signed({2'b0, div_quot[32:0]});
			end
			stsw_pkg::OP_CLAMP:
				ev_q <= tsum_q[34] ? 32'd0 : ((|tsum_q[33:32]) ? 32'hFFFF_FFFF : tsum_q[31:0]);
			stsw_pkg::OP_SQUARE: ev_q <= sqp[63:32];
			stsw_pkg::OP_DECIDE: begin
				ok_q <= okc;
				if (okc) begin
					res_acc_q <= 1'b1;
					if (bt_q == 32'd0) begin
						res_scale_q <= (bo_q == 32'd0) ? stsw_pkg::SCALE_ONE : stsw_pkg::SCALE_MAX;
					end
				end
			end
			stsw_pkg::OP_SQRT_INIT: begin
				sq_q   <= div_quot;
				sres_q <= '0;
				sbit_q <= 64'h4000_0000_0000_0000;
			end
			stsw_pkg::OP_SQRT_STEP: begin
				if (sq_q >= strial) begin
					sq_q   <= sq_q - strial;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			stsw_pkg::OP_SCL_SAT:
				res_scale_q <= (sres_q > 64'(stsw_pkg::SCALE_MAX)) ?
					stsw_pkg::SCALE_MAX : sres_q[17:0];
			stsw_pkg::OP_EMIT: begin
				oatt_q   <= res_att_q;
				oacc_q   <= res_acc_q;
				odir_q   <= res_dir_q;
				orung_q  <= rung_ext[5:0];
				obeta_q  <= bn_q;
				oscale_q <= res_scale_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		st            = '0;
		st.div_busy   = div_busy;
		st.is_switch  = div_rem == 32'd0;
		st.dir_nz     = res_dir_q != stsw_pkg::DIR_NONE;
		st.accept_now = !d_q[33] || (delta_q == 32'd0);
		st.y_big      = yq_q >= stsw_pkg::Y_LIMIT;
		st.ok         = ok_q;
		st.newb_zero  = bt_q == 32'd0;
		st.clr_last   = clr_addr_q == RW'(TEMPS - 1);
		st.out_free   = !ovalid_q || !out_stall;
		st.iter       = iter_q;
	end

	assign out_valid      = ovalid_q;
	assign attempted      = oatt_q;
	assign accepted       = oacc_q;
	assign direction      = $signed(odir_q);
	assign rung_index     = orung_q;
	assign beta_now       = obeta_q;
	assign momentum_scale = oscale_q;

	a_rung_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rung_q <= top)
		else $error("rung beyond top rung");

	a_acc_has_att: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && oacc_q |-> oatt_q && odir_q != stsw_pkg::DIR_NONE)
		else $error("accepted move without attempt or direction");

	a_reject_unit_scale: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !oacc_q |-> oscale_q == stsw_pkg::SCALE_ONE)
		else $error("scale changed without an accepted move");

	a_emit_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		op == stsw_pkg::OP_EMIT |-> !div_busy)
		else $error("result sent while divider busy");

endmodule

// ===== rtl/simulated_tempering_switch.sv =====
// Simulated tempering temperature move: top level.
// One item is taken at a time. A step that is not a switch step is dominated by the
// step-modulo pass of the shared radix-2 divider. A switch step with a legal move
// adds two mean divisions; a move that needs the Metropolis exponential adds 16
// Taylor terms, each with a term division, and an accepted move whose target beta is
// nonzero adds a ratio division and a square root. The next item is accepted while a
// result waits at the output register. After reset the rung statistics memory is
// cleared, one entry per cycle, before the first item is taken; configuration writes
// are taken at any time but belong between items, when no item is in flight.
module simulated_tempering_switch #(
	parameter int TEMPS = stsw_pkg::TEMPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        step_number,
	input  logic signed [31:0] potential,
	input  logic [15:0]        uniform_draw,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               attempted,
	output logic               accepted,
	output logic signed [1:0]  direction,
	output logic [5:0]         rung_index,
	output logic [31:0]        beta_now,
	output logic [17:0]        momentum_scale
);

	stsw_pkg::dp_op_t   op;
	stsw_pkg::dp_stat_t st;

	assign cfg_ready = 1'b1;

	stsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.op       (op)
	);

	stsw_dp #(.TEMPS(TEMPS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.st             (st),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.step_number    (step_number),
		.potential      (potential),
		.uniform_draw   (uniform_draw),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.attempted      (attempted),
		.accepted       (accepted),
		.direction      (direction),
		.rung_index     (rung_index),
		.beta_now       (beta_now),
		.momentum_scale (momentum_scale)
	);

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the simulated tempering switch.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NR = stsw_pkg::TEMPS_DEF;

	typedef enum {K_ITEM, K_CFG, K_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t          kind;
		logic [31:0]        step;
		logic [31:0]        pot;
		logic [15:0]        draw;
		stsw_pkg::cfg_reg_t reg_sel;
		logic [31:0]        data;
	} job_t;

	typedef struct {
		logic        att;
		logic        acc;
		logic [1:0]  dir;
		logic [5:0]  rung;
		logic [31:0] beta;
		logic [17:0] scale;
	} move_t;

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic in_valid = 0, in_stall;
	logic [31:0] step_number = 0;
	logic signed [31:0] potential = 0;
	logic [15:0] uniform_draw = 0;
	logic out_valid, out_stall = 1;
	logic attempted, accepted;
	logic signed [1:0] direction;
	logic [5:0] rung_index;
	logic [31:0] beta_now;
	logic [17:0] momentum_scale;

	simulated_tempering_switch u_top (.*);

	always #5 clk = ~clk;

	job_t  jobs[$];
	move_t moves_due[$];
	int    errors = 0;
	logic  in_taken = 0, cfg_taken = 0, out_taken = 0;

	// model state
	logic [31:0] m_beta_min, m_beta_step;
	logic [6:0]  m_temps;
	logic [15:0] m_period;
	logic [5:0]  m_rung;
	logic        m_seen[NR];
	longint      m_sum[NR];
	int unsigned m_cnt[NR];

	function automatic int unsigned rungs_used();
		int unsigned n;
		n = m_temps;
		if (n < 1) n = 1;
		if (n > NR) n = NR;
		return n;
	endfunction

	function automatic logic [31:0] rung_beta(int unsigned i);
		longint unsigned b;
		b = longint'(m_beta_min) + longint'(i) * longint'(m_beta_step);
		return b > 64'hFFFF_FFFF ? stsw_pkg::BETA_SAT : b[31:0];
	endfunction

	function automatic longint rung_mean(int unsigned i);
		if (!m_seen[i] || m_cnt[i] == 0) return 0;
		return m_sum[i] / longint'(m_cnt[i]);
	endfunction

	function automatic logic [31:0] boltzmann_q16(longint unsigned yq);
		longint unsigned r, term, v;
		longint sum;
		if (yq >= (12 << 16)) return 0;
		r = yq << 12;
		term = 64'h1_0000_0000;
		sum = term;
		for (int k = 1; k <= 16; k++) begin
			term = (term * r) >> 32;
			term = term / k;
			if (k & 1) sum -= term; else sum += term;
		end
		if (sum < 0) sum = 0;
		if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
		v = sum;
		for (int s = 0; s < 4; s++) v = (v * v) >> 32;
		return v >> 16;
	endfunction

	function automatic logic [17:0] kinetic_scale(logic [31:0] ob, logic [31:0] nb);
		longint unsigned q, res, b;
		if (nb == 0) return ob == 0 ? stsw_pkg::SCALE_ONE : stsw_pkg::SCALE_MAX;
		q = {ob, 32'h0} / longint'(nb);
		res = 0;
		b = 64'h1 << 62;
		while (b > q) b >>= 2;
		while (b != 0) begin
			if (q >= res + b) begin
				q -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res > stsw_pkg::SCALE_MAX ? stsw_pkg::SCALE_MAX : res[17:0];
	endfunction

	function automatic move_t tempering_move(logic [31:0] stp, logic [31:0] pot,
		logic [15:0] u);
		move_t r;
		int unsigned per, n, tgt;
		int dir;
		logic [31:0] bo, bt;
		longint unsigned delta, a, yq;
		longint v, mc, mt, m, d;
		logic ok;
		per = m_period == 0 ? 1 : m_period;
		v = longint'(signed'(pot));
		dir = 0;
		r.att = 0;
		r.acc = 0;
		r.scale = stsw_pkg::SCALE_ONE;
		if (stp % per == 0) begin
			n = rungs_used();
			r.att = 1;
			m_seen[m_rung] = 1;
			if (m_cnt[m_rung] < stsw_pkg::COUNT_MAX) begin
				m_sum[m_rung] += v;
				m_cnt[m_rung]++;
			end
			if (u >= stsw_pkg::HALF_DRAW && m_rung + 1 < n) dir = 1;
			else if (u < stsw_pkg::HALF_DRAW && m_rung > 0) dir = -1;
			if (dir != 0) begin
				tgt = dir > 0 ? m_rung + 1 : m_rung - 1;
				bo = rung_beta(m_rung);
				bt = rung_beta(tgt);
				delta = dir > 0 ? 32'(bt - bo) : 32'(bo - bt);
				mc = rung_mean(m_rung);
				mt = rung_mean(tgt);
				if (dir > 0 && !m_seen[tgt]) m = mc;
				else m = (mc + mt) / 2;
				d = dir > 0 ? m - v : v - m;
				if (d >= 0 || delta == 0) begin
					ok = 1;
				end else begin
					a = -d;
					yq = (a >> 24) * delta + (((a & 64'hFF_FFFF) * delta) >> 24);
					ok = boltzmann_q16(yq) >= u;
				end
				if (ok) begin
					r.acc = 1;
					m_rung = 6'(tgt);
					r.scale = kinetic_scale(bo, bt);
				end
			end
		end
		r.dir = dir > 0 ? stsw_pkg::DIR_UP : dir < 0 ? stsw_pkg::DIR_DN : stsw_pkg::DIR_NONE;
		r.rung = m_rung;
		r.beta = rung_beta(m_rung);
		return r;
	endfunction

	task automatic cmp_field(string f, longint unsigned e, longint unsigned a);
		if (e !== a) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, f, e, a);
		end
	endtask

	// monitor: apply transfers to the model and check results
	always @(posedge clk) begin
		move_t e;
		in_taken <= in_valid && !in_stall;
		cfg_taken <= cfg_valid && cfg_ready;
		out_taken <= out_valid && !out_stall;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (stsw_pkg::cfg_reg_t'(cfg_index))
					stsw_pkg::REG_BETA_MIN: m_beta_min = cfg_data;
					stsw_pkg::REG_BETA_STEP: m_beta_step = cfg_data;
					stsw_pkg::REG_NUM_TEMPS: begin
						m_temps = cfg_data[6:0];
						m_rung = 6'(rungs_used() - 1);
					end
					stsw_pkg::REG_PERIOD: m_period = cfg_data[15:0];
				endcase
			end
			if (in_valid && !in_stall)
				moves_due = {moves_due, tempering_move(step_number, potential, uniform_draw)};
			if (out_valid && !out_stall) begin
				if (moves_due.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, actual rung %0d", $time,
						rung_index);
				end else begin
					e = moves_due.pop_front();
					cmp_field("attempted", e.att, attempted);
					cmp_field("accepted", e.acc, accepted);
					cmp_field("direction", e.dir, $unsigned(direction));
					cmp_field("rung_index", e.rung, rung_index);
					cmp_field("beta_now", e.beta, beta_now);
					cmp_field("momentum_scale", e.scale, momentum_scale);
				end
			end
		end
	end

	function automatic int draw_wait(int n);
		return ((n / 60) % 3 == 0) ? 0 : $urandom_range(0, 18);
	endfunction

	// driver
	int sent = 0, gap = 0, quiet = 0;
	always @(negedge clk) begin
		logic nv, ncv, busy;
		nv = in_valid && !in_taken;
		ncv = cfg_valid && !cfg_taken;
		busy = nv || ncv;
		if (arst_n && !busy) begin
			if (gap > 0) begin
				gap--;
			end else if (jobs.size() > 0) begin
				case (jobs[0].kind)
					K_ITEM: begin
						step_number <= jobs[0].step;
						potential <= jobs[0].pot;
						uniform_draw <= jobs[0].draw;
						void'(jobs.pop_front());
						nv = 1;
						sent++;
						gap = draw_wait(sent);
					end
					K_DRAIN: if (moves_due.size() == 0) void'(jobs.pop_front());
					K_CFG: if (moves_due.size() == 0) begin
						if (quiet < 40) begin
							quiet++;
						end else begin
							quiet = 0;
							cfg_index <= jobs[0].reg_sel;
							cfg_data <= jobs[0].data;
							void'(jobs.pop_front());
							ncv = 1;
						end
					end
				endcase
			end
		end
		in_valid <= nv;
		cfg_valid <= ncv;
	end

	// receiver
	int got = 0, stall_left = 0;
	always @(negedge clk) begin
		if (out_taken) begin
			got++;
			stall_left = (got == 150) ? 400 : draw_wait(got + 30);
		end
		out_stall <= stall_left > 0;
		if (stall_left > 0) stall_left--;
	end

	task automatic add_item(logic [31:0] s, logic [31:0] p, logic [15:0] u);
		job_t j;
		j.kind = K_ITEM;
		j.step = s;
		j.pot = p;
		j.draw = u;
		jobs = {jobs, j};
	endtask

	task automatic add_cfg(stsw_pkg::cfg_reg_t r, logic [31:0] d);
		job_t j;
		j.kind = K_CFG;
		j.reg_sel = r;
		j.data = d;
		jobs = {jobs, j};
	endtask

	task automatic add_drain();
		job_t j;
		j.kind = K_DRAIN;
		jobs = {jobs, j};
	endtask

	initial begin
		logic [31:0] per, s, base, p;
		m_beta_min = stsw_pkg::BETA_MIN_RST;
		m_beta_step = stsw_pkg::BETA_STEP_RST;
		m_temps = stsw_pkg::NUM_TEMPS_RST;
		m_period = stsw_pkg::PERIOD_RST;
		m_rung = 6'(NR - 1);
		foreach (m_seen[i]) begin
			m_seen[i] = 0;
			m_sum[i] = 0;
			m_cnt[i] = 0;
		end

		add_item(0, 32'h8000_0000, 16'h0000);
		add_item(32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
		add_item(5, 0, 16'h7FFF);
		add_item(6, 32'h7FFF_FFFF, 16'h8000);
		add_cfg(stsw_pkg::REG_BETA_STEP, 32'h0010_0000);
		add_cfg(stsw_pkg::REG_NUM_TEMPS, 4);
		add_item(1, 32'h0010_0000, 16'h0000);
		add_item(2, 32'h0020_0000, 16'hFFFF);
		add_item(3, 32'hFFF0_0000, 16'hFFFF);
		add_item(4, 32'h0050_0000, 16'h8000);
		add_item(5, 32'h0000_0000, 16'h0001);
		add_item(6, 32'h0100_0000, 16'h0000);
		add_item(7, 32'h8000_0000, 16'hFFFF);
		add_cfg(stsw_pkg::REG_PERIOD, 0);
		add_cfg(stsw_pkg::REG_BETA_MIN, 32'hFFFF_FFF0);
		add_item(9, 32'h0001_0000, 16'hFFFF);
		add_item(10, 32'h0001_0000, 16'h0000);
		add_cfg(stsw_pkg::REG_NUM_TEMPS, 1);
		add_cfg(stsw_pkg::REG_PERIOD, 3);
		add_item(3, 32'h1234_5678, 16'hFFFF);
		add_item(4, 32'h1234_5678, 16'h0000);
		add_cfg(stsw_pkg::REG_BETA_MIN, 0);
		add_cfg(stsw_pkg::REG_NUM_TEMPS, 2);
		add_item(6, 32'h0, 16'hFFFF);
		add_item(9, 32'h0, 16'h0000);

		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 3))
				0: add_cfg(stsw_pkg::REG_BETA_MIN, 0);
				1: add_cfg(stsw_pkg::REG_BETA_MIN, 32'hFFFF_FFFF);
				default: add_cfg(stsw_pkg::REG_BETA_MIN, $urandom_range(0, 32'h0400_0000));
			endcase
			case ($urandom_range(0, 4))
				0: add_cfg(stsw_pkg::REG_BETA_STEP, 0);
				1: add_cfg(stsw_pkg::REG_BETA_STEP, 32'hFFFF_FFFF);
				2: add_cfg(stsw_pkg::REG_BETA_STEP, $urandom());
				default: add_cfg(stsw_pkg::REG_BETA_STEP, $urandom_range(1, 32'h0040_0000));
			endcase
			case ($urandom_range(0, 5))
				0: add_cfg(stsw_pkg::REG_NUM_TEMPS, 64);
				1: add_cfg(stsw_pkg::REG_NUM_TEMPS, $urandom_range(65, 127));
				2: add_cfg(stsw_pkg::REG_NUM_TEMPS, $urandom_range(0, 1));
				default: add_cfg(stsw_pkg::REG_NUM_TEMPS, $urandom_range(2, 10));
			endcase
			case ($urandom_range(0, 5))
				0: per = 0;
				1: per = 16'hFFFF;
				2: per = $urandom_range(2, 5);
				default: per = 1;
			endcase
			add_cfg(stsw_pkg::REG_PERIOD, per);
			if (per == 0) per = 1;
			base = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			for (int k = 0; k < 80; k++) begin
				if (k == 40) add_drain();
				s = ($urandom_range(0, 3) == 0) ? $urandom() : per * $urandom_range(0, 65535);
				case ($urandom_range(0, 7))
					0: p = $urandom();
					default: p = base + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
				endcase
				add_item(s, p, $urandom_range(0, 65535));
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		while (jobs.size() > 0 || in_valid || cfg_valid) @(posedge clk);
		while (moves_due.size() > 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#50ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
